FILE: hdl/flow_key_hash_table_unit_assert.svh
// Assertion macros for the checker file of the flow key hash table.
`ifndef FLOW_KEY_HASH_TABLE_UNIT_ASSERT_SVH
`define FLOW_KEY_HASH_TABLE_UNIT_ASSERT_SVH

// An implication that must hold at every clock edge outside reset.
`define FKH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// An implication whose consequent is checked at the next clock edge.
`define FKH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/fkh_pkg.sv
//------------------------------------------------------------------------------
// Flow key hash table package
// Shared request and result types and status and action codes.
//------------------------------------------------------------------------------
`default_nettype none
package fkh_pkg;

    localparam logic [1:0] ACT_LOOKUP  = 2'd0;
    localparam logic [1:0] ACT_REMOVE  = 2'd1;
    localparam logic [1:0] ACT_DUP     = 2'd2;

    localparam logic [1:0] ST_FOUND    = 2'd0;
    localparam logic [1:0] ST_INSERTED = 2'd1;
    localparam logic [1:0] ST_REMOVED  = 2'd2;
    localparam logic [1:0] ST_FAILED   = 2'd3;

    localparam int KEY_W   = 128;
    localparam int COUNT_W = 14;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] ack_number;
    } fkh_request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  bucket;
        logic [2:0]  slot;
        logic [13:0] live_count;
    } fkh_result_t;

    function automatic logic [KEY_W-1:0] key_of(input fkh_request_t r);
        return {r.src_addr, r.dst_addr, r.src_port, r.dst_port, r.ack_number};
    endfunction

endpackage
`default_nettype wire

FILE: hdl/fkh_ram.sv
//------------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
//------------------------------------------------------------------------------
`default_nettype none
module fkh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: hdl/fkh_front.sv
//------------------------------------------------------------------------------
// Flow key hash table front end
// Accepts requests, computes the bucket and queues them for the back end.
//------------------------------------------------------------------------------
`default_nettype none
module fkh_front
    import fkh_pkg::*;
#(
    parameter int BUCKETS = 1024
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire fkh_request_t               request,
    output logic                            busy,
    output logic                            q_valid,
    output fkh_request_t                    q_request,
    output logic [$clog2(BUCKETS)-1:0]      q_bucket,
    input  wire logic                       q_pop
);
    localparam int BW = $clog2(BUCKETS);

    logic              full_reg, full_next;
    fkh_request_t      req_reg;
    logic [BW-1:0]     bkt_reg;
    logic [31:0]       hash;

    assign hash = request.src_addr ^ request.dst_addr ^ {16'd0, request.src_port}
                ^ {16'd0, request.dst_port} ^ request.ack_number;
    assign busy      = full_reg;
    assign q_valid   = full_reg;
    assign q_request = req_reg;
    assign q_bucket  = bkt_reg;

    always_comb
    begin
        full_next = full_reg;
        if (q_pop)
        begin
            full_next = 1'b0;
        end
        if (start && !full_reg)
        begin
            full_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !full_reg)
        begin
            req_reg <= request;
            bkt_reg <= hash[BW-1:0];
        end
    end
endmodule
`default_nettype wire

FILE: hdl/fkh_back.sv
//------------------------------------------------------------------------------
// Flow key hash table back end
// Clears the valid marks after reset, then reads a bucket one slot per cycle, decides the action and writes back.
//------------------------------------------------------------------------------
`default_nettype none
module fkh_back
    import fkh_pkg::*;
#(
    parameter int BUCKETS = 1024,
    parameter int WAYS    = 8
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   q_valid,
    input  wire fkh_request_t           q_request,
    input  wire logic [$clog2(BUCKETS)-1:0] q_bucket,
    output logic                        q_pop,
    output logic                        done,
    output fkh_result_t                 result
);
    localparam int BW    = $clog2(BUCKETS);
    localparam int WW    = $clog2(WAYS);
    localparam int AW    = BW + WW;
    localparam int DEPTH = BUCKETS * (2 ** WW);

    typedef enum logic [1:0] { S_CLEAR, S_IDLE, S_READ, S_DECIDE } state_t;

    state_t            state_reg;
    logic [BW-1:0]     clr_idx_reg;
    fkh_request_t      req_reg;
    logic [BW-1:0]     bkt_reg;
    logic [WW:0]       rd_idx_reg;
    logic [WW:0]       cmp_idx_reg;
    logic              cmp_ok_reg;
    logic [WAYS-1:0]   vbits_reg;
    logic [WAYS-1:0]   match_reg;
    logic [COUNT_W-1:0] count_reg;
    logic              done_reg;
    fkh_result_t       result_reg;

    logic [KEY_W-1:0]  rdata;
    logic              we;
    logic [AW-1:0]     waddr, raddr;
    logic [KEY_W-1:0]  key;

    logic [WAYS-1:0]   vrdata;
    logic              v_we;
    logic [BW-1:0]     v_waddr;
    logic [WAYS-1:0]   v_wdata;
    logic [WAYS-1:0]   slot_mask;

    logic              hit;
    logic [WW-1:0]     hit_w;
    logic              free;
    logic [WW-1:0]     free_w;
    logic              dup;
    logic [WW-1:0]     dup_w;
    logic [1:0]        st;
    logic [WW-1:0]     sl;
    logic              set_v, clr_v;

    assign key   = key_of(req_reg);
    assign raddr = {bkt_reg, rd_idx_reg[WW-1:0]};
    assign q_pop = (state_reg == S_IDLE) && q_valid;
    assign done   = done_reg;
    assign result = result_reg;

    fkh_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_keys (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (key),
        .raddr (raddr),
        .rdata (rdata)
    );

    fkh_ram #(.WIDTH(WAYS), .DEPTH(BUCKETS)) u_valid (
        .clk   (clk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .raddr (q_bucket),
        .rdata (vrdata)
    );

    always_comb
    begin
        hit = 1'b0; hit_w = '0; free = 1'b0; free_w = '0; dup = 1'b0; dup_w = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                hit = 1'b1; hit_w = WW'(i);
            end
            if (!vbits_reg[i])
            begin
                free = 1'b1; free_w = WW'(i);
            end
        end
        for (int i = WAYS - 2; i >= 0; i--)
        begin
            if (match_reg[i] && !vbits_reg[i+1])
            begin
                dup = 1'b1; dup_w = WW'(i + 1);
            end
        end
        st = ST_FAILED; sl = '0; set_v = 1'b0; clr_v = 1'b0;
        case (req_reg.action)
            ACT_LOOKUP:
            begin
                if (hit)
                begin
                    st = ST_FOUND; sl = hit_w;
                end
                else if (free)
                begin
                    st = ST_INSERTED; sl = free_w; set_v = 1'b1;
                end
            end
            ACT_REMOVE:
            begin
                if (hit)
                begin
                    st = ST_REMOVED; sl = hit_w; clr_v = 1'b1;
                end
            end
            ACT_DUP:
            begin
                if (dup)
                begin
                    st = ST_INSERTED; sl = dup_w; set_v = 1'b1;
                end
            end
            default:
            begin
                st = ST_FAILED;
            end
        endcase
        we        = (state_reg == S_DECIDE) && set_v;
        waddr     = {bkt_reg, sl};
        slot_mask = WAYS'(1) << sl;
        v_we      = (state_reg == S_CLEAR) || ((state_reg == S_DECIDE) && (set_v || clr_v));
        if (state_reg == S_CLEAR)
        begin
            v_waddr = clr_idx_reg;
            v_wdata = '0;
        end
        else
        begin
            v_waddr = bkt_reg;
            v_wdata = set_v ? (vbits_reg | slot_mask) : (vbits_reg & ~slot_mask);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_idx_reg <= '0;
            count_reg   <= '0;
            done_reg    <= 1'b0;
            result_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                    if (clr_idx_reg == BW'(BUCKETS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    if (cmp_idx_reg == (WW+1)'(WAYS - 1) && cmp_ok_reg)
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    state_reg <= S_IDLE;
                    done_reg  <= 1'b1;
                    if (set_v)
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                    else if (clr_v)
                    begin
                        count_reg <= count_reg - 1'b1;
                    end
                    result_reg.status     <= st;
                    result_reg.bucket     <= 10'(bkt_reg);
                    result_reg.slot       <= 3'(sl);
                    result_reg.live_count <= set_v ? count_reg + 1'b1
                                           : clr_v ? count_reg - 1'b1 : count_reg;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                req_reg     <= q_request;
                bkt_reg     <= q_bucket;
                rd_idx_reg  <= '0;
                cmp_ok_reg  <= 1'b0;
                cmp_idx_reg <= '0;
            end
            S_READ:
            begin
                if (!cmp_ok_reg)
                begin
                    vbits_reg <= vrdata;
                end
                if (rd_idx_reg != (WW+1)'(WAYS))
                begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                end
                cmp_ok_reg <= 1'b1;
                if (cmp_ok_reg)
                begin
                    match_reg[cmp_idx_reg[WW-1:0]] <= vbits_reg[cmp_idx_reg[WW-1:0]]
                                                      && (rdata == key);
                    cmp_idx_reg <= cmp_idx_reg + 1'b1;
                end
            end
            default:
            begin
                cmp_ok_reg <= 1'b0;
            end
        endcase
    end
endmodule
`default_nettype wire

FILE: hdl/flow_key_hash_table_unit.sv
//------------------------------------------------------------------------------
// Flow key hash table unit
// Set-associative flow table with lookup-or-insert, remove and duplicate insert.
//------------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The result appears on
// the result port for one cycle with done high, and the receiver cannot stall
// it. The back end takes a request from the front register, reads and compares
// the slots of its bucket one per cycle, then decides and writes back, and it
// takes no new request before it is through with the last one. One more
// request can wait in the front register meanwhile. After reset the valid
// marks are cleared in a pass over all buckets, and a request taken during
// that pass waits for it to end.
`default_nettype none
module flow_key_hash_table_unit
    import fkh_pkg::*;
#(
    parameter int BUCKETS = 1024,
    parameter int WAYS    = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire fkh_request_t request,
    output logic              busy,
    output logic              done,
    output fkh_result_t       result
);
    logic                       q_valid;
    logic                       q_pop;
    fkh_request_t               q_request;
    logic [$clog2(BUCKETS)-1:0] q_bucket;

    fkh_front #(.BUCKETS(BUCKETS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .request   (request),
        .busy      (busy),
        .q_valid   (q_valid),
        .q_request (q_request),
        .q_bucket  (q_bucket),
        .q_pop     (q_pop)
    );

    fkh_back #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_request (q_request),
        .q_bucket  (q_bucket),
        .q_pop     (q_pop),
        .done      (done),
        .result    (result)
    );
endmodule
`default_nettype wire

FILE: hdl/fkh_checker.sv
//------------------------------------------------------------------------------
// Flow key hash table checker
// Port-level properties of the flow key hash table unit.
//------------------------------------------------------------------------------
`default_nettype none
`include "flow_key_hash_table_unit_assert.svh"
module fkh_checker
    import fkh_pkg::*;
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         start,
    input wire logic         busy,
    input wire logic         done,
    input wire fkh_result_t  result
);
    `FKH_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy,
        "busy must follow an accepted request")
    `FKH_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done,
        "done must last one cycle")
    `FKH_ASSERT_IMP(a_fail_slot, clk, rst_n, done && result.status == ST_FAILED,
        result.slot == 3'd0, "failed result must give slot zero")
endmodule

bind flow_key_hash_table_unit fkh_checker u_fkh_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .result  (result)
);
`default_nettype wire

FILE: verif/flow_key_hash_table_unit_test.sv
//------------------------------------------------------------------------------
// Flow key hash table unit testbench
// Sends lookup, remove, duplicate-insert and unused requests with and without
// random gaps, and compares all result fields to a behavioral flow table model.
//------------------------------------------------------------------------------
`default_nettype none
module flow_key_hash_table_unit_test;
    import fkh_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUCKETS = 1024;
    localparam int WAYS    = 8;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic         clk;
    logic         rst_n;
    logic         start;
    fkh_request_t request;
    logic         busy;
    logic         done;
    fkh_result_t  result;

    flow_key_hash_table_unit #(.BUCKETS(BUCKETS), .WAYS(WAYS)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .request(request),
        .busy(busy), .done(done), .result(result)
    );

    logic [KEY_W-1:0] table_key   [BUCKETS*WAYS];
    logic             table_valid [BUCKETS*WAYS];
    logic [13:0]      table_count;

    fkh_result_t expected_results[$];
    fkh_request_t flow_pool[$];
    int error_count;
    int idle_cycles;
    bit gaps_on;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [KEY_W-1:0] flow_key(input fkh_request_t r);
        return {r.src_addr, r.dst_addr, r.src_port, r.dst_port, r.ack_number};
    endfunction

    function automatic fkh_result_t apply_flow_action(input fkh_request_t r);
        fkh_result_t res;
        logic [31:0] h;
        int b;
        int s;
        logic [KEY_W-1:0] k;
        bit finished;
        k = flow_key(r);
        h = r.src_addr ^ r.dst_addr ^ {16'd0, r.src_port} ^ {16'd0, r.dst_port}
            ^ r.ack_number;
        b = h % BUCKETS;
        res.status = ST_FAILED;
        res.bucket = b[9:0];
        res.slot = 3'd0;
        finished = 1'b0;
        if (r.action == ACT_LOOKUP)
        begin
            for (s = 0; s < WAYS && !finished; s++)
                if (table_valid[b*WAYS+s] && table_key[b*WAYS+s] == k)
                begin
                    res.status = ST_FOUND;
                    res.slot = s[2:0];
                    finished = 1'b1;
                end
            for (s = 0; s < WAYS && !finished; s++)
                if (!table_valid[b*WAYS+s])
                begin
                    table_valid[b*WAYS+s] = 1'b1;
                    table_key[b*WAYS+s] = k;
                    table_count = table_count + 14'd1;
                    res.status = ST_INSERTED;
                    res.slot = s[2:0];
                    finished = 1'b1;
                end
        end
        else if (r.action == ACT_REMOVE)
        begin
            for (s = 0; s < WAYS && !finished; s++)
                if (table_valid[b*WAYS+s] && table_key[b*WAYS+s] == k)
                begin
                    table_valid[b*WAYS+s] = 1'b0;
                    table_count = table_count - 14'd1;
                    res.status = ST_REMOVED;
                    res.slot = s[2:0];
                    finished = 1'b1;
                end
        end
        else if (r.action == ACT_DUP)
        begin
            for (s = 0; s < WAYS && !finished; s++)
                if (table_valid[b*WAYS+s] && table_key[b*WAYS+s] == k)
                begin
                    if (s == WAYS - 1)
                        finished = 1'b1;
                    else if (!table_valid[b*WAYS+s+1])
                    begin
                        table_valid[b*WAYS+s+1] = 1'b1;
                        table_key[b*WAYS+s+1] = k;
                        table_count = table_count + 14'd1;
                        res.status = ST_INSERTED;
                        res.slot = s[2:0] + 3'd1;
                        finished = 1'b1;
                    end
                end
        end
        res.live_count = table_count;
        return res;
    endfunction

    task automatic send_request(input fkh_request_t r);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 19);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        request <= r;
        @(posedge clk);
        while (busy) @(posedge clk);
        expected_results.push_back(apply_flow_action(r));
    endtask

    function automatic fkh_request_t random_flow(input logic [1:0] act);
        fkh_request_t r;
        r.action = act;
        r.src_addr = $urandom;
        r.dst_addr = $urandom;
        r.src_port = 16'($urandom);
        r.dst_port = 16'($urandom);
        r.ack_number = $urandom;
        return r;
    endfunction

    // Keys that share a bucket: the same bits are flipped in src_addr and
    // ack_number, so the XOR hash does not change.
    function automatic fkh_request_t bucket_mate(input fkh_request_t base_req, input int n);
        fkh_request_t r;
        r = base_req;
        r.src_addr = base_req.src_addr ^ (n << 16);
        r.ack_number = base_req.ack_number ^ (n << 16);
        return r;
    endfunction

    task automatic wait_for_drain();
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (2 * WAYS + 8) @(posedge clk);
    endtask

    task automatic test_field_extremes();
        fkh_request_t r;
        r = '0;
        r.action = ACT_LOOKUP;
        send_request(r);
        send_request(r);
        r.action = ACT_REMOVE;
        send_request(r);
        send_request(r);
        r = {ACT_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF};
        send_request(r);
        r.action = ACT_DUP;
        send_request(r);
        r.action = ACT_UNUSED;
        send_request(r);
        r.action = ACT_REMOVE;
        send_request(r);
        send_request(r);
        r.action = ACT_DUP;
        send_request(r);
    endtask

    task automatic test_full_bucket();
        fkh_request_t base_req;
        fkh_request_t r;
        int n;
        base_req = random_flow(ACT_LOOKUP);
        for (n = 0; n < WAYS + 1; n++)
            send_request(bucket_mate(base_req, n));
        r = bucket_mate(base_req, WAYS - 1);
        r.action = ACT_DUP;
        send_request(r);
        r = bucket_mate(base_req, 2);
        r.action = ACT_REMOVE;
        send_request(r);
        r = bucket_mate(base_req, 1);
        r.action = ACT_DUP;
        send_request(r);
        send_request(r);
        r = bucket_mate(base_req, 0);
        r.action = ACT_DUP;
        send_request(r);
    endtask

    task automatic test_random_traffic(input int count);
        fkh_request_t r;
        int i;
        int pick;
        for (i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (flow_pool.size() == 0 || pick < 25)
            begin
                r = random_flow(ACT_LOOKUP);
                if ($urandom_range(0, 1) && flow_pool.size() != 0)
                    r = bucket_mate(flow_pool[$urandom_range(0, flow_pool.size() - 1)],
                                    $urandom_range(1, 15));
                if (flow_pool.size() < 64)
                    flow_pool.push_back(r);
            end
            else
                r = flow_pool[$urandom_range(0, flow_pool.size() - 1)];
            if (pick >= 97)
                r.action = ACT_UNUSED;
            else if (pick >= 70)
                r.action = ACT_REMOVE;
            else if (pick >= 50)
                r.action = ACT_DUP;
            else
                r.action = ACT_LOOKUP;
            send_request(r);
        end
    endtask

    always @(posedge clk)
    begin
        fkh_result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, result);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             result.status);
                    error_count++;
                end
                if (result.bucket !== want.bucket)
                begin
                    $display("%0t: bucket expected %0d actual %0d", $time, want.bucket,
                             result.bucket);
                    error_count++;
                end
                if (result.slot !== want.slot)
                begin
                    $display("%0t: slot expected %0d actual %0d", $time, want.slot,
                             result.slot);
                    error_count++;
                end
                if (result.live_count !== want.live_count)
                begin
                    $display("%0t: live_count expected %0d actual %0d", $time,
                             want.live_count, result.live_count);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        int i;
        error_count = 0;
        idle_cycles = 0;
        gaps_on = 1'b1;
        start = 1'b0;
        request = '0;
        rst_n = 1'b0;
        table_count = '0;
        for (i = 0; i < BUCKETS * WAYS; i++)
            table_valid[i] = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_field_extremes();
        test_full_bucket();
        wait_for_drain();
        test_random_traffic(1200);
        gaps_on = 1'b0;
        test_random_traffic(500);
        wait_for_drain();
        if (error_count == 0 && expected_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
